FILE: design/led_cube_layer_scan_driver_assert.svh
// Assertion macros for the LED cube layer scan driver.
// Each macro takes a label, clock, reset, antecedent and consequent.
`ifndef LED_CUBE_LAYER_SCAN_DRIVER_ASSERT_SVH
`define LED_CUBE_LAYER_SCAN_DRIVER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define LCLS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcls assertion failed");
// next-cycle implication
`define LCLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcls assertion failed");
`else
`define LCLS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LCLS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: design/lcls_pkg.sv
package lcls_pkg;

   // build defaults
   localparam int LAYERS_DEFAULT    = 8;
   localparam int CMD_DEPTH_DEFAULT = 2;

   // geometry of one layer and of one scan
   localparam int ROWS   = 8;
   localparam int BEAT_W = 4;   // 16 shift beats: top bit is the pass, low bits the bit

   // register indexes
   localparam logic [1:0] CSR_SCAN_MODE       = 2'd0;
   localparam logic [1:0] CSR_SPECTRUM_DWELL  = 2'd1;
   localparam logic [1:0] CSR_ANIMATION_DWELL = 2'd2;

   // scan mode codes
   localparam logic [1:0] MODE_SPECTRUM  = 2'd1;
   localparam logic [1:0] MODE_ANIMATION = 2'd2;

   localparam logic [10:0] SPECTRUM_DWELL_RESET  = 11'd700;
   localparam logic [10:0] ANIMATION_DWELL_RESET = 11'd500;

   // no layer driven
   localparam logic [7:0] SEL_NONE = 8'hff;

   typedef struct packed {
      logic       req_type;
      logic [2:0] layer_index;
      logic [2:0] row_index;
      logic [7:0] pixel_byte;
   } req_item_type;

   typedef struct packed {
      logic        lane_red_low;
      logic        lane_green_low;
      logic        lane_red_high;
      logic        lane_green_high;
      logic        latch_strobe;
      logic [7:0]  layer_select;
      logic [10:0] dwell;
      logic        last;
   } rsp_item_type;

   typedef enum logic {
      CMD_WRITE,
      CMD_SCAN
   } cmd_kind_type;

   // classified command between front and back
   typedef struct packed {
      cmd_kind_type kind;
      logic         spectrum;
      logic [10:0]  dwell;
      logic [2:0]   layer;
      logic [2:0]   row;
      logic [7:0]   pixel;
   } cmd_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SHIFT,
      SEQ_LATCH
   } seq_state_type;

   // row carried on a lane in each pass: 0,2,4,5 then 3,1,6,7
   function automatic logic [2:0] pass_row(input logic pass, input logic [1:0] lane);
      logic [2:0] row;
      case ({pass, lane})
         3'd0:    row = 3'd0;
         3'd1:    row = 3'd2;
         3'd2:    row = 3'd4;
         3'd3:    row = 3'd5;
         3'd4:    row = 3'd3;
         3'd5:    row = 3'd1;
         3'd6:    row = 3'd6;
         3'd7:    row = 3'd7;
         default: row = 3'd0;
      endcase
      return row;
   endfunction

   // active-low layer drive; spectrum mirrors nothing, animation drives 7 - layer
   function automatic logic [7:0] layer_select(input logic spectrum, input logic [3:0] layer);
      logic [2:0] pos;
      logic [7:0] sel;
      pos = spectrum ? layer[2:0] : ~layer[2:0];
      if (layer > 4'd7) begin
         sel = SEL_NONE;
      end else begin
         sel = ~(8'h01 << pos);
      end
      return sel;
   endfunction

endpackage

FILE: design/lcls_front.sv
module lcls_front #(
   parameter int LAYERS = lcls_pkg::LAYERS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  lcls_pkg::req_item_type req_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [10:0]            csr_wdata,
   output logic                   q_push,
   output lcls_pkg::cmd_type      q_cmd,
   input  logic                   q_full
);
   import lcls_pkg::*;

   logic [1:0]  scan_mode_ff, scan_mode_in;
   logic [10:0] spectrum_dwell_ff, spectrum_dwell_in;
   logic [10:0] animation_dwell_ff, animation_dwell_in;
   logic        accept;
   logic        scan_on;
   logic        layer_ok;

   // configuration registers, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      scan_mode_in       = scan_mode_ff;
      spectrum_dwell_in  = spectrum_dwell_ff;
      animation_dwell_in = animation_dwell_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SCAN_MODE:       scan_mode_in       = csr_wdata[1:0];
            CSR_SPECTRUM_DWELL:  spectrum_dwell_in  = csr_wdata;
            CSR_ANIMATION_DWELL: animation_dwell_in = csr_wdata;
            default:             ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_mode_ff       <= 2'd0;
         spectrum_dwell_ff  <= SPECTRUM_DWELL_RESET;
         animation_dwell_ff <= ANIMATION_DWELL_RESET;
      end else begin
         scan_mode_ff       <= scan_mode_in;
         spectrum_dwell_ff  <= spectrum_dwell_in;
         animation_dwell_ff <= animation_dwell_in;
      end
   end

   // accept and classify; dropped beats never reach the queue
   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign scan_on  = (scan_mode_ff == MODE_SPECTRUM) || (scan_mode_ff == MODE_ANIMATION);
   assign layer_ok = int'(req_item.layer_index) < LAYERS;

   always_comb begin
      q_push         = accept && (req_item.req_type ? scan_on : layer_ok);
      q_cmd.kind     = req_item.req_type ? CMD_SCAN : CMD_WRITE;
      q_cmd.spectrum = (scan_mode_ff == MODE_SPECTRUM);
      q_cmd.dwell    = (scan_mode_ff == MODE_SPECTRUM) ? spectrum_dwell_ff
                                                       : animation_dwell_ff;
      q_cmd.layer    = req_item.layer_index;
      q_cmd.row      = req_item.row_index;
      q_cmd.pixel    = req_item.pixel_byte;
   end

endmodule

FILE: design/lcls_cmd_queue.sv
module lcls_cmd_queue #(
   parameter int DEPTH = lcls_pkg::CMD_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lcls_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output lcls_pkg::cmd_type head
);
   import lcls_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type          slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: design/lcls_back.sv
module lcls_back #(
   parameter int LAYERS = lcls_pkg::LAYERS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  lcls_pkg::cmd_type      q_head,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output lcls_pkg::rsp_item_type rsp_item
);
   import lcls_pkg::*;

   localparam int LW = $clog2(LAYERS);

   // frame store: one 64-bit line per layer, byte written, line read
   logic [ROWS-1:0][7:0]       frame_mem [LAYERS];
   logic [LAYERS-1:0][ROWS-1:0] valid_ff;
   logic [ROWS-1:0][7:0]       rd_data_ff;
   logic [ROWS-1:0]            rd_valid_ff;

   seq_state_type     state_ff, state_in;
   logic [BEAT_W-1:0] beat_ff, beat_in;
   logic [LW-1:0]     layer_ff, layer_in;
   logic              spectrum_ff, spectrum_in;
   logic [10:0]       dwell_ff, dwell_in;
   rsp_item_type      out_ff, out_in;
   logic              out_valid_ff, out_valid_in;

   logic              out_free;
   logic              wr_en;
   logic              rd_en;
   logic [LW-1:0]     wr_layer;
   logic [7:0]        row_byte [ROWS];
   logic [3:0]        lane_bits;
   rsp_item_type      shift_item;
   rsp_item_type      latch_item;

   assign out_free = !out_valid_ff || rsp_pop;
   assign wr_en    = q_pop && (q_head.kind == CMD_WRITE);
   assign rd_en    = q_pop && (q_head.kind == CMD_SCAN);
   assign wr_layer = LW'(q_head.layer);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[wr_layer][q_head.row] <= q_head.pixel;
      end
      if (rd_en) begin
         rd_data_ff  <= frame_mem[layer_ff];
         rd_valid_ff <= valid_ff[layer_ff];
      end
   end

   // rows never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_layer][q_head.row] <= 1'b1;
      end
   end

   always_comb begin
      for (int r = 0; r < ROWS; r++) begin
         row_byte[r] = rd_valid_ff[r] ? rd_data_ff[r] : 8'h00;
      end
   end

   // lane bits: inverted, MSB first, pass picked by the beat's top bit
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         lane_bits[l] = ~row_byte[pass_row(beat_ff[BEAT_W-1], 2'(l))][~beat_ff[2:0]];
      end
   end

   always_comb begin
      shift_item.lane_red_low    = lane_bits[0];
      shift_item.lane_green_low  = lane_bits[1];
      shift_item.lane_red_high   = lane_bits[2];
      shift_item.lane_green_high = lane_bits[3];
      shift_item.latch_strobe    = 1'b0;
      shift_item.layer_select    = SEL_NONE;
      shift_item.dwell           = 11'd0;
      shift_item.last            = 1'b0;

      latch_item.lane_red_low    = 1'b0;
      latch_item.lane_green_low  = 1'b0;
      latch_item.lane_red_high   = 1'b0;
      latch_item.lane_green_high = 1'b0;
      latch_item.latch_strobe    = 1'b1;
      latch_item.layer_select    = layer_select(spectrum_ff, 4'(layer_ff));
      latch_item.dwell           = dwell_ff;
      latch_item.last            = 1'b1;
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (rd_en) state_in = SEQ_SHIFT;
         end
         SEQ_SHIFT: begin
            if (out_free && (beat_ff == '1)) state_in = SEQ_LATCH;
         end
         SEQ_LATCH: begin
            if (out_free) state_in = SEQ_IDLE;
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // sequencer outputs and datapath updates
   always_comb begin
      q_pop        = 1'b0;
      beat_in      = beat_ff;
      layer_in     = layer_ff;
      spectrum_in  = spectrum_ff;
      dwell_in     = dwell_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      case (state_ff)
         SEQ_IDLE: begin
            q_pop       = !q_empty;
            beat_in     = '0;
            spectrum_in = q_head.spectrum;
            dwell_in    = q_head.dwell;
         end
         SEQ_SHIFT: begin
            if (out_free) begin
               out_in       = shift_item;
               out_valid_in = 1'b1;
               beat_in      = beat_ff + BEAT_W'(1);
            end
         end
         SEQ_LATCH: begin
            if (out_free) begin
               out_in       = latch_item;
               out_valid_in = 1'b1;
               layer_in     = (layer_ff == LW'(LAYERS - 1)) ? '0 : layer_ff + LW'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         beat_ff      <= '0;
         layer_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         beat_ff      <= beat_in;
         layer_ff     <= layer_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      spectrum_ff <= spectrum_in;
      dwell_ff    <= dwell_in;
      out_ff      <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_ff;

endmodule

FILE: design/led_cube_layer_scan_driver.sv
// Channel   Handshake              Payload
// req       req_push / req_full    req_item  (write byte or scan tick)
// rsp       rsp_pop / rsp_empty    rsp_item  (16 shift beats, then one latch beat)
// csr       csr_valid / csr_ready  csr_index, csr_wdata
//
// A write is handled by the back sequencer in its idle state; a scan tick runs
// one frame line read, 16 shift beats and one latch beat, and the output
// register gives one result beat per cycle while rsp is not stalled.
// Synchronous active-high reset; the frame store reads as zero after reset.
// The command queue lets the front take beats while the back is busy or
// while rsp is stalled; req_full rises once the queue fills.
`include "led_cube_layer_scan_driver_assert.svh"

module led_cube_layer_scan_driver #(
   parameter int LAYERS    = lcls_pkg::LAYERS_DEFAULT,
   parameter int CMD_DEPTH = lcls_pkg::CMD_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  lcls_pkg::req_item_type req_item,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output lcls_pkg::rsp_item_type rsp_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [10:0]            csr_wdata
);
   import lcls_pkg::*;

   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_empty;
   cmd_type q_cmd;
   cmd_type q_head;
   logic    shift_beat;
   logic    shift_quiet;

   lcls_front #(
      .LAYERS (LAYERS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_push    (q_push),
      .q_cmd     (q_cmd),
      .q_full    (q_full)
   );

   lcls_cmd_queue #(
      .DEPTH (CMD_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   lcls_back #(
      .LAYERS (LAYERS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   // shift beat on the output and its quiet fields
   assign shift_beat  = !rsp_empty && !rsp_item.latch_strobe;
   assign shift_quiet = (rsp_item.layer_select == SEL_NONE) && (rsp_item.dwell == 11'd0)
                        && !rsp_item.last;

   // queue never overflows or underflows
   `LCLS_ASSERT_IMPL(a_no_push_full, clock, reset, q_push, !q_full)
   `LCLS_ASSERT_IMPL(a_no_pop_empty, clock, reset, q_pop, !q_empty)
   // shift beats carry no layer drive and no dwell
   `LCLS_ASSERT_IMPL(a_shift_quiet, clock, reset, shift_beat, shift_quiet)
   // the back takes no new command while a scan is still running
   `LCLS_ASSERT_NEXT(a_scan_busy, clock, reset, q_pop && (q_head.kind == CMD_SCAN), !q_pop)

endmodule
